[rtl/rhp_pkg.sv]
// RTP header parser package: result record, status and register codes, header constants.
// Used by the interfaces, the parser, the result queue, the top level and the checker.
package rhp_pkg;

  // Fixed header layout and limits.
  localparam int unsigned HDR_LEN    = 12;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned TYPE_W     = 7;
  localparam logic [7:0]  VERSION_BYTE = 8'd128;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;

  // Byte positions that end each header field.
  localparam logic [CNT_W-1:0] IDX_VERSION = CNT_W'(0);
  localparam logic [CNT_W-1:0] IDX_TYPE    = CNT_W'(1);
  localparam logic [CNT_W-1:0] IDX_SEQ_END = CNT_W'(4);
  localparam logic [CNT_W-1:0] IDX_TS_END  = CNT_W'(8);
  localparam logic [CNT_W-1:0] IDX_HDR_END = CNT_W'(HDR_LEN);

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_VER  = 3'd3,
    ST_BAD_TYPE = 3'd4
  } rhp_status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } rhp_kind_e;

  typedef enum logic {
    CFG_MIN_TYPE = 1'b0,
    CFG_MAX_TYPE = 1'b1
  } rhp_cfg_idx_e;

  typedef struct packed {
    rhp_kind_e         kind;
    logic [7:0]        payload_byte;
    rhp_status_e       status;
    logic [TYPE_W-1:0] payload_type;
    logic [15:0]       sequence_number;
    logic [31:0]       rtp_timestamp;
    logic [31:0]       source_id;
    logic [15:0]       payload_length;
    logic [31:0]       arrival_stamp;
    logic              last_result;
  } rhp_result_t;

  // Write strobes from the parser into the result queue.
  typedef struct packed {
    logic push_a;
    logic push_b;
  } rhp_push_t;

endpackage

[rtl/rhp_if.sv]
// Channel interfaces of the RTP header parser: byte input, result output, register writes.
// Depends on rhp_pkg for field widths.
interface rhp_in_if import rhp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] arrival_time;

  modport source (output valid, data_byte, last_byte, arrival_time, input ready);
  modport sink (input valid, data_byte, last_byte, arrival_time, output ready);
endinterface

interface rhp_out_if import rhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        payload_byte;
  logic [2:0]        status;
  logic [TYPE_W-1:0] payload_type;
  logic [15:0]       sequence_number;
  logic [31:0]       rtp_timestamp;
  logic [31:0]       source_id;
  logic [15:0]       payload_length;
  logic [31:0]       arrival_stamp;
  logic              last_result;

  modport source (output valid, kind, payload_byte, status, payload_type, sequence_number,
                  rtp_timestamp, source_id, payload_length, arrival_stamp, last_result,
                  input ready);
  modport sink (input valid, kind, payload_byte, status, payload_type, sequence_number,
                rtp_timestamp, source_id, payload_length, arrival_stamp, last_result,
                output ready);
endinterface

interface rhp_cfg_if import rhp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              index;
  logic [TYPE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/rtp_header_parser_core.sv]
// A byte accepted is held in the input register, then written into the result queue once
// the queue has room. Bytes are taken one per cycle while the queue has room; results leave
// one per cycle from a four-entry queue while the receiver is ready, and a payload byte that
// ends a packet gives two results. Reset (async, active low) clears the packet state, empties
// the queue and sets the payload type range to 0..127.
module rtp_header_parser_core import rhp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  rhp_in_if.sink  in_i,
  rhp_out_if.source out_o,
  rhp_cfg_if.sink cfg_i
);

  logic [TYPE_W-1:0] min_type_q, max_type_q;
  logic              room;
  rhp_push_t         push;
  rhp_result_t       res_a, res_b;

  // Payload type range registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_type_q <= '0;
      max_type_q <= '1;
    end else if (cfg_i.valid) begin
      case (rhp_cfg_idx_e'(cfg_i.index))
        CFG_MIN_TYPE: min_type_q <= cfg_i.data;
        CFG_MAX_TYPE: max_type_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  rhp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .min_type_i (min_type_q),
    .max_type_i (max_type_q),
    .room_i     (room),
    .push_o     (push),
    .res_a_o    (res_a),
    .res_b_o    (res_b)
  );

  rhp_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_a_i (res_a),
    .res_b_i (res_b),
    .room_o  (room),
    .out_o   (out_o)
  );

endmodule

[rtl/rhp_parse.sv]
// Input register, header capture and result building for the RTP header parser.
// Depends on rhp_pkg and rhp_in_if.
module rhp_parse import rhp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  rhp_in_if.sink            in_i,
  input  logic [TYPE_W-1:0] min_type_i,
  input  logic [TYPE_W-1:0] max_type_i,
  input  logic              room_i,
  output rhp_push_t         push_o,
  output rhp_result_t       res_a_o,
  output rhp_result_t       res_b_o
);

  logic              in_vld_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [31:0]       time_q;
  logic              fire;
  logic              accept;

  logic [CNT_W-1:0]  byte_cnt_q, byte_cnt_d, cnt_inc, len_diff;
  logic              ver_good_q, ver_good_d;
  logic              type_good_q, type_good_d;
  logic [TYPE_W-1:0] type_q, type_d;
  logic [15:0]       seq_q, seq_d;
  logic [31:0]       stamp_q, stamp_d;
  logic [31:0]       src_q, src_d;
  logic              is_payload;
  logic [15:0]       plen;
  rhp_status_e       status;
  rhp_result_t       pay_res, sum_res;

  // The input register frees up whenever its request can move into the queue.
  assign fire     = in_vld_q && room_i;
  assign in_i.ready = !in_vld_q || room_i;
  assign accept   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.last_byte;
      time_q <= in_i.arrival_time;
    end
  end

  // Header field capture by byte position.
  always_comb begin
    ver_good_d  = ver_good_q;
    type_good_d = type_good_q;
    type_d      = type_q;
    seq_d       = seq_q;
    stamp_d     = stamp_q;
    src_d       = src_q;
    is_payload  = 1'b0;
    if (byte_cnt_q == IDX_VERSION) begin
      ver_good_d  = (byte_q == VERSION_BYTE);
      type_good_d = 1'b0;
      type_d      = '0;
      seq_d       = '0;
      stamp_d     = '0;
      src_d       = '0;
    end else if (byte_cnt_q == IDX_TYPE) begin
      type_d      = byte_q[TYPE_W-1:0];
      type_good_d = (byte_q[TYPE_W-1:0] >= min_type_i) && (byte_q[TYPE_W-1:0] <= max_type_i);
    end else if (byte_cnt_q < IDX_SEQ_END) begin
      seq_d = {seq_q[7:0], byte_q};
    end else if (byte_cnt_q < IDX_TS_END) begin
      stamp_d = {stamp_q[23:0], byte_q};
    end else if (byte_cnt_q < IDX_HDR_END) begin
      src_d = {src_q[23:0], byte_q};
    end else begin
      is_payload = 1'b1;
    end
  end

  // Saturating byte count, payload length and ranked status.
  always_comb begin
    cnt_inc  = (byte_cnt_q == COUNT_MAX) ? byte_cnt_q : byte_cnt_q + CNT_W'(1);
    len_diff = cnt_inc - IDX_HDR_END;
    if (cnt_inc > IDX_HDR_END) begin
      plen = len_diff[CNT_W-1] ? LEN_MAX : len_diff[15:0];
    end else begin
      plen = '0;
    end
    if (cnt_inc < IDX_HDR_END) begin
      status = ST_SHORT;
    end else if (cnt_inc == IDX_HDR_END) begin
      status = ST_EMPTY;
    end else if (!ver_good_d) begin
      status = ST_BAD_VER;
    end else if (!type_good_d) begin
      status = ST_BAD_TYPE;
    end else begin
      status = ST_OK;
    end
    byte_cnt_d = last_q ? '0 : cnt_inc;
  end

  // Result records: a payload byte and the packet summary.
  always_comb begin
    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = byte_q;
    pay_res.last_result  = !last_q;

    sum_res                 = '0;
    sum_res.kind            = KIND_SUMMARY;
    sum_res.status          = status;
    sum_res.payload_type    = type_d;
    sum_res.sequence_number = seq_d;
    sum_res.rtp_timestamp   = stamp_d;
    sum_res.source_id       = src_d;
    sum_res.payload_length  = plen;
    sum_res.arrival_stamp   = time_q;
    sum_res.last_result     = 1'b1;
  end

  // A payload byte that ends the packet gives two results, payload first.
  assign push_o.push_a = fire && (is_payload || last_q);
  assign push_o.push_b = fire && is_payload && last_q;
  assign res_a_o       = is_payload ? pay_res : sum_res;
  assign res_b_o       = sum_res;

  // Packet state advances once per byte that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= '0;
      ver_good_q  <= 1'b0;
      type_good_q <= 1'b0;
      type_q      <= '0;
      seq_q       <= '0;
      stamp_q     <= '0;
      src_q       <= '0;
    end else if (fire) begin
      byte_cnt_q  <= byte_cnt_d;
      ver_good_q  <= ver_good_d;
      type_good_q <= type_good_d;
      type_q      <= type_d;
      seq_q       <= seq_d;
      stamp_q     <= stamp_d;
      src_q       <= src_d;
    end
  end

endmodule

[rtl/rhp_res_fifo.sv]
// Result queue of the RTP header parser: takes up to two results a cycle, hands out one.
// Depends on rhp_pkg and rhp_out_if.
module rhp_res_fifo import rhp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rhp_push_t   push_i,
  input  rhp_result_t res_a_i,
  input  rhp_result_t res_b_i,
  output logic        room_o,
  rhp_out_if.source   out_o
);

  rhp_result_t           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;
  rhp_result_t           head;

  // Room for the largest burst a single byte can cause.
  assign room_o     = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign pop        = out_o.valid && out_o.ready;
  assign wr_ptr_nxt = wr_ptr_q + FIFO_PTR_W'(1);

  always_comb begin
    cnt_d = cnt_q + FIFO_CNT_W'(push_i.push_a) + FIFO_CNT_W'(push_i.push_b)
          - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_ptr_q] <= res_a_i;
    end
    if (push_i.push_b) begin
      mem_q[wr_ptr_nxt] <= res_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_i.push_a) + FIFO_PTR_W'(push_i.push_b);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Head entry drives the output channel.
  assign head                  = mem_q[rd_ptr_q];
  assign out_o.valid           = cnt_q != '0;
  assign out_o.kind            = head.kind;
  assign out_o.payload_byte    = head.payload_byte;
  assign out_o.status          = head.status;
  assign out_o.payload_type    = head.payload_type;
  assign out_o.sequence_number = head.sequence_number;
  assign out_o.rtp_timestamp   = head.rtp_timestamp;
  assign out_o.source_id       = head.source_id;
  assign out_o.payload_length  = head.payload_length;
  assign out_o.arrival_stamp   = head.arrival_stamp;
  assign out_o.last_result     = head.last_result;

endmodule

[rtl/rhp_checker.sv]
// Port-level checks on the result channel of the RTP header parser, bound to the top level.
// Depends on rhp_pkg for status and kind codes.
module rhp_checker import rhp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        kind_i,
  input logic [2:0]  status_i,
  input logic [15:0] payload_length_i
);

  // Summary results always close the results of their byte.
  // (last_result is not checked here.)

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Payload results carry no status or length.
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_PAYLOAD) |-> (status_i == ST_OK) && (payload_length_i == '0))
    else $error("payload result carries summary fields");

  // Short or empty packets have no payload length.
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_SUMMARY) && ((status_i == ST_SHORT) || (status_i == ST_EMPTY))
    |-> payload_length_i == '0)
    else $error("short packet reports payload");

  // Packets past the header checks have at least one payload byte.
  a_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_SUMMARY) &&
    ((status_i == ST_OK) || (status_i == ST_BAD_VER) || (status_i == ST_BAD_TYPE))
    |-> payload_length_i != '0)
    else $error("full packet reports empty payload");

endmodule

bind rtp_header_parser_core rhp_checker u_rhp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .kind_i           (out_o.kind),
  .status_i         (out_o.status),
  .payload_length_i (out_o.payload_length)
);

[sim/tb_rtp_header_parser_core.sv]
// Self-checking testbench for rtp_header_parser_core: streams RTP packet bytes in, predicts
// payload and summary results, and checks every result field. Depends on rhp_pkg, rhp_if.
`timescale 1ns / 1ps

module tb_rtp_header_parser_core;
  import rhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_BYTES = 120;
  localparam int unsigned LONG_PKT_LEN = 64;

  // One packet byte waiting to be offered to the parser.
  typedef struct {
    logic [7:0]  data;
    logic        fin;
    logic [31:0] arrival;
  } byte_req_t;

  logic clk_i;
  logic rst_ni;

  rhp_in_if  in_if ();
  rhp_out_if out_if ();
  rhp_cfg_if cfg_if ();

  rtp_header_parser_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Packet parsing state mirrored from the block.
  logic [CNT_W-1:0]  pkt_len;
  logic              ver_ok;
  logic              type_ok;
  logic [TYPE_W-1:0] cap_type;
  logic [15:0]       cap_seq;
  logic [31:0]       cap_ts;
  logic [31:0]       cap_ssrc;
  logic [TYPE_W-1:0] type_lo;
  logic [TYPE_W-1:0] type_hi;

  byte_req_t   bytes_to_send[$];
  rhp_result_t expected_results[$];
  byte_req_t   next_byte;
  int unsigned bytes_queued;
  int unsigned bytes_accepted;
  int unsigned errors;
  bit          byte_taken;
  bit          reg_taken;
  bit          random_started;
  bit          hold_off;
  logic        quiet;

  // Neither side idles for a stretch of the run.
  assign quiet = (bytes_accepted >= 400) && (bytes_accepted < 700);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the parser state by one byte and record the results it must produce.
  task automatic parse_byte(input logic [7:0] b, input logic fin, input logic [31:0] arr);
    rhp_result_t      r;
    logic [CNT_W-1:0] plen;
    if (pkt_len == 0) begin
      ver_ok   = (b == VERSION_BYTE);
      type_ok  = 1'b0;
      cap_type = '0;
      cap_seq  = '0;
      cap_ts   = '0;
      cap_ssrc = '0;
    end else if (pkt_len == 1) begin
      cap_type = b[TYPE_W-1:0];
      type_ok  = (cap_type >= type_lo) && (cap_type <= type_hi);
    end else if (pkt_len < 4) begin
      cap_seq = {cap_seq[7:0], b};
    end else if (pkt_len < 8) begin
      cap_ts = {cap_ts[23:0], b};
    end else if (pkt_len < HDR_LEN) begin
      cap_ssrc = {cap_ssrc[23:0], b};
    end else begin
      r = '0;
      r.kind = KIND_PAYLOAD;
      r.payload_byte = b;
      r.last_result = !fin;
      expected_results.push_back(r);
    end
    if (pkt_len != COUNT_MAX) pkt_len = pkt_len + 1'b1;

    // The final byte closes the packet with a summary.
    if (fin) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      plen = (pkt_len > HDR_LEN) ? CNT_W'(pkt_len - HDR_LEN) : '0;
      r.payload_length = (plen > LEN_MAX) ? LEN_MAX : plen[15:0];
      if (pkt_len < HDR_LEN) r.status = ST_SHORT;
      else if (pkt_len == HDR_LEN) r.status = ST_EMPTY;
      else if (!ver_ok) r.status = ST_BAD_VER;
      else if (!type_ok) r.status = ST_BAD_TYPE;
      else r.status = ST_OK;
      r.payload_type = cap_type;
      r.sequence_number = cap_seq;
      r.rtp_timestamp = cap_ts;
      r.source_id = cap_ssrc;
      r.arrival_stamp = arr;
      r.last_result = 1'b1;
      expected_results.push_back(r);
      pkt_len = '0;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Sample all three channels at the rising edge.
  always @(posedge clk_i) begin : watch_channels
    rhp_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request pending");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_if.kind);
          check_field("payload_byte", want.payload_byte, out_if.payload_byte);
          check_field("status", want.status, out_if.status);
          check_field("payload_type", want.payload_type, out_if.payload_type);
          check_field("sequence_number", want.sequence_number, out_if.sequence_number);
          check_field("rtp_timestamp", want.rtp_timestamp, out_if.rtp_timestamp);
          check_field("source_id", want.source_id, out_if.source_id);
          check_field("payload_length", want.payload_length, out_if.payload_length);
          check_field("arrival_stamp", want.arrival_stamp, out_if.arrival_stamp);
          check_field("last_result", want.last_result, out_if.last_result);
        end
      end
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.data_byte, in_if.last_byte, in_if.arrival_time);
        bytes_accepted++;
        byte_taken = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_MIN_TYPE) type_lo = cfg_if.data;
        else type_hi = cfg_if.data;
        reg_taken = 1'b1;
      end
    end
  end

  // Byte driver: a new request goes out once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || byte_taken)) begin
      byte_taken = 1'b0;
      if (bytes_to_send.size() != 0 && (quiet || $urandom_range(0, 99) >= 13)) begin
        next_byte = bytes_to_send.pop_front();
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= next_byte.data;
        in_if.last_byte    <= next_byte.fin;
        in_if.arrival_time <= next_byte.arrival;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= !hold_off && (quiet || $urandom_range(0, 99) >= 13);
  end

  initial begin
    hold_off = 1'b0;
    wait (random_started);
    repeat (40) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  task automatic queue_byte(input logic [7:0] b, input logic fin, input logic [31:0] arr);
    byte_req_t req;
    req.data = b;
    req.fin = fin;
    req.arrival = arr;
    bytes_to_send.push_back(req);
    bytes_queued++;
  endtask

  // Mostly well-formed packets with random content; the rest carry a bad version or type.
  task automatic queue_packet(input int unsigned len, input bit force_good);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0 && (force_good || $urandom_range(0, 9) != 0)) b = VERSION_BYTE;
      if (i == 1 && type_lo <= type_hi && (force_good || $urandom_range(0, 4) != 0))
        b = {b[7], 7'($urandom_range(type_lo, type_hi))};
      queue_byte(b, i == len - 1, $urandom);
    end
  endtask

  task automatic write_reg(input rhp_cfg_idx_e idx, input logic [TYPE_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(negedge clk_i); while (!reg_taken);
    reg_taken = 1'b0;
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every byte was taken and every result arrived, then let the pipe settle.
  task automatic drain();
    do @(negedge clk_i); while (bytes_accepted != bytes_queued || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [TYPE_W-1:0] lo, input logic [TYPE_W-1:0] hi);
    int unsigned start;
    write_reg(CFG_MIN_TYPE, lo);
    write_reg(CFG_MAX_TYPE, hi);
    start = bytes_queued;
    while (bytes_queued - start < PHASE_BYTES) begin
      if ($urandom_range(0, 9) == 0) queue_packet($urandom_range(1, 12), 1'b0);
      else queue_packet($urandom_range(13, 48), 1'b0);
    end
    drain();
  endtask

  initial begin
    logic [TYPE_W-1:0] lo;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    in_if.arrival_time = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MIN_TYPE;
    cfg_if.data = '0;
    pkt_len = '0;
    ver_ok = 1'b0;
    type_ok = 1'b0;
    cap_type = '0;
    cap_seq = '0;
    cap_ts = '0;
    cap_ssrc = '0;
    type_lo = '0;
    type_hi = '1;
    bytes_queued = 0;
    bytes_accepted = 0;
    errors = 0;
    byte_taken = 1'b0;
    reg_taken = 1'b0;
    random_started = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_MIN_TYPE, 7'd0);
    write_reg(CFG_MAX_TYPE, 7'd127);

    // A one-byte packet ends inside the header: summary only, too short.
    queue_byte(8'hFF, 1'b1, 32'hFFFF_FFFF);
    // A bare header with all-ones fields reports an empty payload.
    queue_byte(VERSION_BYTE, 1'b0, 32'h0);
    queue_byte(8'h7F, 1'b0, 32'h0);
    for (int i = 2; i < 11; i++) queue_byte(8'hFF, 1'b0, 32'h0);
    queue_byte(8'hFF, 1'b1, 32'h0);
    // Smallest good packet: type bit seven set is ignored, one zero payload byte.
    queue_byte(VERSION_BYTE, 1'b0, 32'h0);
    queue_byte(8'h80, 1'b0, 32'h0);
    for (int i = 2; i < 12; i++) queue_byte(8'h00, 1'b0, 32'h0);
    queue_byte(8'h00, 1'b1, 32'h8000_0001);
    drain();

    // Random packets under several type ranges, including an inverted one.
    random_started = 1'b1;
    run_phase(7'd0, 7'd127);
    run_phase(7'd0, 7'd0);
    run_phase(7'd127, 7'd127);
    run_phase(7'd100, 7'd20);
    lo = 7'($urandom_range(0, 127));
    run_phase(lo, 7'($urandom_range(lo, 127)));
    lo = 7'($urandom_range(0, 127));
    run_phase(lo, 7'($urandom_range(lo, 127)));

    // One longer well-formed packet with a run of payload bytes.
    write_reg(CFG_MIN_TYPE, 7'd0);
    write_reg(CFG_MAX_TYPE, 7'd127);
    queue_packet(LONG_PKT_LEN, 1'b1);
    drain();
    repeat (10) @(posedge clk_i);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rhp_pkg.sv
rtl/rhp_if.sv
rtl/rhp_parse.sv
rtl/rhp_res_fifo.sv
rtl/rtp_header_parser_core.sv
rtl/rhp_checker.sv
sim/tb_rtp_header_parser_core.sv
